[rtl/copg_pkg.sv]
package copg_pkg;

	localparam int COORD_W  = 8;
	localparam int RADIUS_W = 6;
	localparam int COLOR_W  = 16;
	localparam int DEC_W    = 12;

	localparam logic signed [DEC_W-1:0] DEC_INIT   = DEC_W'(3);
	localparam logic signed [DEC_W-1:0] DEC_INC_LO = DEC_W'(6);
	localparam logic signed [DEC_W-1:0] DEC_INC_HI = DEC_W'(10);

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

endpackage

[rtl/copg_in_if.sv]
interface copg_in_if;
	logic                          valid;
	logic                          ready;
	logic [copg_pkg::COORD_W-1:0]  center_x;
	logic [copg_pkg::COORD_W-1:0]  center_y;
	logic [copg_pkg::RADIUS_W-1:0] radius;
	logic [copg_pkg::COLOR_W-1:0]  color;

	modport source (output valid, center_x, center_y, radius, color, input ready);
	modport sink (input valid, center_x, center_y, radius, color, output ready);
endinterface

[rtl/copg_out_if.sv]
interface copg_out_if;
	logic                         valid;
	logic                         ready;
	logic [copg_pkg::COORD_W-1:0] x_plus_a;
	logic [copg_pkg::COORD_W-1:0] x_minus_a;
	logic [copg_pkg::COORD_W-1:0] x_plus_b;
	logic [copg_pkg::COORD_W-1:0] x_minus_b;
	logic [copg_pkg::COORD_W-1:0] y_plus_a;
	logic [copg_pkg::COORD_W-1:0] y_minus_a;
	logic [copg_pkg::COORD_W-1:0] y_plus_b;
	logic [copg_pkg::COORD_W-1:0] y_minus_b;
	logic [copg_pkg::COLOR_W-1:0] point_color;
	logic                         last_of_circle;

	modport source (output valid, x_plus_a, x_minus_a, x_plus_b, x_minus_b,
		y_plus_a, y_minus_a, y_plus_b, y_minus_b, point_color, last_of_circle,
		input ready);
	modport sink (input valid, x_plus_a, x_minus_a, x_plus_b, x_minus_b,
		y_plus_a, y_minus_a, y_plus_b, y_minus_b, point_color, last_of_circle,
		output ready);
endinterface

[rtl/circle_octant_point_generator_unit.sv]
// First word: a circle's first word is offered in the cycle after the request is taken.
// Throughput: one word per cycle while out ready is high, one word per decision-loop
// step plus one for the diagonal when a meets b; a new request is taken only after
// the last word of a circle. The single decision loop register set sets this rate.
// Reset: arst_n returns the controller to idle at once; datapath registers are not reset.
module circle_octant_point_generator_unit (
	input logic           clk,
	input logic           arst_n,
	copg_in_if.sink       in_ch,
	copg_out_if.source    out_ch
);
	import copg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	copg_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	copg_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.center_x    (in_ch.center_x),
		.center_y    (in_ch.center_y),
		.radius      (in_ch.radius),
		.color       (in_ch.color),
		.x_plus_a    (out_ch.x_plus_a),
		.x_minus_a   (out_ch.x_minus_a),
		.x_plus_b    (out_ch.x_plus_b),
		.x_minus_b   (out_ch.x_minus_b),
		.y_plus_a    (out_ch.y_plus_a),
		.y_minus_a   (out_ch.y_minus_a),
		.y_plus_b    (out_ch.y_plus_b),
		.y_minus_b   (out_ch.y_minus_b),
		.point_color (out_ch.point_color)
	);

	assign out_ch.last_of_circle = status.last;

endmodule

[rtl/copg_datapath.sv]
module copg_datapath (
	input  logic                          clk,
	input  copg_pkg::dp_cmd_t             cmd,
	output copg_pkg::dp_status_t          status,
	input  logic [copg_pkg::COORD_W-1:0]  center_x,
	input  logic [copg_pkg::COORD_W-1:0]  center_y,
	input  logic [copg_pkg::RADIUS_W-1:0] radius,
	input  logic [copg_pkg::COLOR_W-1:0]  color,
	output logic [copg_pkg::COORD_W-1:0]  x_plus_a,
	output logic [copg_pkg::COORD_W-1:0]  x_minus_a,
	output logic [copg_pkg::COORD_W-1:0]  x_plus_b,
	output logic [copg_pkg::COORD_W-1:0]  x_minus_b,
	output logic [copg_pkg::COORD_W-1:0]  y_plus_a,
	output logic [copg_pkg::COORD_W-1:0]  y_minus_a,
	output logic [copg_pkg::COORD_W-1:0]  y_plus_b,
	output logic [copg_pkg::COORD_W-1:0]  y_minus_b,
	output logic [copg_pkg::COLOR_W-1:0]  point_color
);
	import copg_pkg::*;

	logic [COORD_W-1:0]         cx_q;
	logic [COORD_W-1:0]         cy_q;
	logic [COLOR_W-1:0]         color_q;
	logic [RADIUS_W-1:0]        a_q;
	logic [RADIUS_W-1:0]        b_q;
	logic signed [DEC_W-1:0]    d_q;
	logic [RADIUS_W-1:0]        a_nxt;
	logic [RADIUS_W-1:0]        b_nxt;
	logic signed [DEC_W-1:0]    d_nxt;
	logic signed [DEC_W-1:0]    a_ext;
	logic signed [DEC_W-1:0]    b_ext;
	logic signed [DEC_W-1:0]    d_init;
	logic [COORD_W-1:0]         a_c;
	logic [COORD_W-1:0]         b_c;

	always_comb begin
		a_ext  = $signed(DEC_W'(a_q));
		b_ext  = $signed(DEC_W'(b_q));
		d_init = DEC_INIT - $signed(DEC_W'({radius, 1'b0}));
		a_nxt  = a_q + RADIUS_W'(1);
		if (d_q[DEC_W-1]) begin
			d_nxt = d_q + (a_ext <<< 2) + DEC_INC_LO;
			b_nxt = b_q;
		end else begin
			d_nxt = d_q + ((a_ext - b_ext) <<< 2) + DEC_INC_HI;
			b_nxt = b_q - RADIUS_W'(1);
		end
		status.last = (a_q == b_q) || (a_nxt > b_nxt);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			color_q <= color;
			a_q     <= '0;
			b_q     <= radius;
			d_q     <= d_init;
		end else if (cmd.step) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
			d_q <= d_nxt;
		end
	end

	assign a_c         = COORD_W'(a_q);
	assign b_c         = COORD_W'(b_q);
	assign x_plus_a    = cx_q + a_c;
	assign x_minus_a   = cx_q - a_c;
	assign x_plus_b    = cx_q + b_c;
	assign x_minus_b   = cx_q - b_c;
	assign y_plus_a    = cy_q + a_c;
	assign y_minus_a   = cy_q - a_c;
	assign y_plus_b    = cy_q + b_c;
	assign y_minus_b   = cy_q - b_c;
	assign point_color = color_q;

endmodule

[rtl/copg_controller.sv]
module copg_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output copg_pkg::dp_cmd_t    cmd,
	input  copg_pkg::dp_status_t status
);
	import copg_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import copg_pkg::*;

	localparam int REQUEST_COUNT = 310;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct packed {
		logic [7:0][COORD_W-1:0] coord;
		logic [COLOR_W-1:0]      color;
		logic                    last;
	} point_word_t;

	class circle_point_ledger;
		point_word_t pending_points[$];
		int          errors;
		string       coord_name[8] = '{"x_plus_a", "x_minus_a", "x_plus_b", "x_minus_b",
			"y_plus_a", "y_minus_a", "y_plus_b", "y_minus_b"};

		task log_mismatch(string msg);
			$display("%0t: %s", $time, msg);
			errors++;
		endtask

		function point_word_t octant_word(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
				int a, int b, logic [COLOR_W-1:0] col);
			point_word_t w;
			w.coord[0] = COORD_W'(int'(cx) + a);
			w.coord[1] = COORD_W'(int'(cx) - a);
			w.coord[2] = COORD_W'(int'(cx) + b);
			w.coord[3] = COORD_W'(int'(cx) - b);
			w.coord[4] = COORD_W'(int'(cy) + a);
			w.coord[5] = COORD_W'(int'(cy) - a);
			w.coord[6] = COORD_W'(int'(cy) + b);
			w.coord[7] = COORD_W'(int'(cy) - b);
			w.color    = col;
			w.last     = 1'b0;
			return w;
		endfunction

		function void note_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
				logic [RADIUS_W-1:0] r, logic [COLOR_W-1:0] col);
			int a, b, d;
			a = 0;
			b = int'(r);
			d = 3 - 2 * b;
			while (a < b) begin
				pending_points.push_back(octant_word(cx, cy, a, b, col));
				if (d < 0) begin
					d = d + 4 * a + 6;
				end else begin
					d = d + 4 * (a - b) + 10;
					b--;
				end
				a++;
			end
			if (a == b)
				pending_points.push_back(octant_word(cx, cy, a, b, col));
			pending_points[pending_points.size() - 1].last = 1'b1;
		endfunction

		task check_point(point_word_t got);
			point_word_t want;
			if (pending_points.size() == 0) begin
				log_mismatch("point word with none pending");
				return;
			end
			want = pending_points.pop_front();
			for (int i = 0; i < 8; i++) begin
				if (got.coord[i] !== want.coord[i])
					log_mismatch($sformatf("%s got %0d want %0d", coord_name[i],
						got.coord[i], want.coord[i]));
			end
			if (got.color !== want.color)
				log_mismatch($sformatf("point_color got %h want %h", got.color, want.color));
			if (got.last !== want.last)
				log_mismatch($sformatf("last_of_circle got %b want %b", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	copg_in_if  in_ch();
	copg_out_if out_ch();

	circle_point_ledger ledger = new();

	int burst_left;
	int stall_pct;
	int phase_left;
	int idle_cycles;
	point_word_t seen_word;

	circle_octant_point_generator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			ledger.note_circle(in_ch.center_x, in_ch.center_y, in_ch.radius, in_ch.color);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen_word.coord[0] = out_ch.x_plus_a;
			seen_word.coord[1] = out_ch.x_minus_a;
			seen_word.coord[2] = out_ch.x_plus_b;
			seen_word.coord[3] = out_ch.x_minus_b;
			seen_word.coord[4] = out_ch.y_plus_a;
			seen_word.coord[5] = out_ch.y_minus_a;
			seen_word.coord[6] = out_ch.y_plus_b;
			seen_word.coord[7] = out_ch.y_minus_b;
			seen_word.color    = out_ch.point_color;
			seen_word.last     = out_ch.last_of_circle;
			ledger.check_point(seen_word);
		end
	end

	// stall in phases: none, light, heavy
	always @(posedge clk) begin
		if (phase_left == 0) begin
			case ($urandom_range(4))
				0, 1: stall_pct = 0;
				2: stall_pct = 30;
				3: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			phase_left = $urandom_range(200, 20);
		end else begin
			phase_left--;
		end
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [RADIUS_W-1:0] r, logic [COLOR_W-1:0] col);
		in_ch.valid    <= 1'b1;
		in_ch.center_x <= cx;
		in_ch.center_y <= cy;
		in_ch.radius   <= r;
		in_ch.color    <= col;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// end a burst with a random gap, else keep valid high
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(8, 1);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// let the monitor note the last request before checking the queue
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_circle();
		logic [COORD_W-1:0] cx, cy;
		cx = COORD_W'($urandom_range(255));
		cy = COORD_W'($urandom_range(255));
		case ($urandom_range(7))
			0: cx = $urandom_range(1) ? 8'd0 : 8'd255;
			1: cy = $urandom_range(1) ? 8'd0 : 8'd255;
			default: ;
		endcase
		send_circle(cx, cy, RADIUS_W'($urandom_range(63)), COLOR_W'($urandom_range(65535)));
	endtask

	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.radius   = '0;
		in_ch.color    = '0;
		out_ch.ready   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_circle(8'd128, 8'd128, 6'd0, 16'h0000);
		send_circle(8'd0, 8'd0, 6'd0, 16'hFFFF);
		send_circle(8'd255, 8'd255, 6'd0, 16'h8001);
		send_circle(8'd100, 8'd100, 6'd1, 16'h1234);
		send_circle(8'd100, 8'd100, 6'd2, 16'hEDCB);
		send_circle(8'd100, 8'd100, 6'd3, 16'hF800);
		send_circle(8'd60, 8'd200, 6'd4, 16'h07E0);
		send_circle(8'd60, 8'd200, 6'd5, 16'h001F);
		send_circle(8'd1, 8'd254, 6'd10, 16'hAAAA);
		send_circle(8'd0, 8'd0, 6'd63, 16'hFFFF);
		send_circle(8'd255, 8'd255, 6'd63, 16'h0000);
		send_circle(8'd255, 8'd0, 6'd63, 16'hA5A5);
		send_circle(8'd0, 8'd255, 6'd63, 16'h5A5A);
		send_circle(8'd128, 8'd64, 6'd62, 16'h5555);
		send_circle(8'd64, 8'd128, 6'd31, 16'h0F0F);
		send_circle(8'd200, 8'd30, 6'd32, 16'hF0F0);
		send_circle(8'd2, 8'd3, 6'd7, 16'h0001);
		send_circle(8'd253, 8'd252, 6'd8, 16'h8000);
		wait_drained();

		for (int n = 18; n < REQUEST_COUNT; n++) begin
			send_random_circle();
			if (n % 100 == 99)
				wait_drained();
			else if (n < REQUEST_COUNT - 1)
				pace_sender();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.pending_points.size() != 0)
			ledger.log_mismatch($sformatf("%0d point words never came",
				ledger.pending_points.size()));
		if (ledger.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
